// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SFR_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("sfr check failed");

// Check that an antecedent implies a consequent in the same cycle.
`define SFR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfr check failed");

// Check that an antecedent implies a consequent in the following cycle.
`define SFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfr check failed");

`endif

// ----- sv/sfr_pkg.sv -----
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 3;
    localparam int VERD_W    = 3;
    localparam int PIDX_W    = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int TDATA_W   = 24;
    localparam int TUSER_W   = KIND_W + VERD_W;

    localparam logic [KIND_W-1:0] KIND_DROP    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SOURCE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TARGET  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TYPE    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_LENGTH  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd6;
    localparam logic [KIND_W-1:0] KIND_CRC     = 3'd7;

    localparam logic [VERD_W-1:0] VERD_NONE     = 3'd0;
    localparam logic [VERD_W-1:0] VERD_GOOD     = 3'd1;
    localparam logic [VERD_W-1:0] VERD_CRC_ERR  = 3'd2;
    localparam logic [VERD_W-1:0] VERD_FOREIGN  = 3'd3;
    localparam logic [VERD_W-1:0] VERD_BAD_HDR  = 3'd4;
    localparam logic [VERD_W-1:0] VERD_TOO_LONG = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_HDR_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 3'd4;

    localparam int POS_SYNC_A  = 0;
    localparam int POS_SYNC_B  = 1;
    localparam int POS_SYNC_C  = 2;
    localparam int POS_SOURCE  = 3;
    localparam int POS_TARGET  = 4;
    localparam int POS_TYPE    = 5;
    localparam int POS_LEN_HI  = 6;
    localparam int POS_LEN_LO  = 7;
    localparam int POS_PAYLOAD = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [BYTE_W-1:0] hdr_a;
        logic [BYTE_W-1:0] hdr_b;
        logic [BYTE_W-1:0] hdr_c;
        logic [BYTE_W-1:0] own_addr;
        logic [CFG_W-1:0]  max_len;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic [KIND_W-1:0] field_kind;
        logic [PIDX_W-1:0] payload_index;
        logic              frame_end;
        logic [VERD_W-1:0] verdict;
    } t_result;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/sfr_parser.sv -----
`default_nettype none

module sfr_parser
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire t_cfg              i_cfg,
    output t_result                o_res
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int POS_W = $clog2(MAX_PAYLOAD + POS_PAYLOAD + 2);
    localparam int OFF_W = (POS_W > PIDX_W) ? POS_W : PIDX_W;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [15:0]       r_crc, n_crc;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [BYTE_W-1:0] r_tgt, n_tgt;
    logic [BYTE_W-1:0] r_len_hi, n_len_hi;
    logic [BYTE_W-1:0] r_crc_hi, n_crc_hi;

    logic [15:0]       crc_next;
    logic [15:0]       len_rx;
    logic [15:0]       crc_rx;
    logic [POS_W-1:0]  off;
    logic [OFF_W-1:0]  off_ext;
    logic [BYTE_W-1:0] want;
    logic              too_long;
    logic              hunt;
    t_result           res;

    always_comb begin
        crc_next = crc_feed(r_crc, i_byte);
        len_rx   = {r_len_hi, i_byte};
        crc_rx   = {r_crc_hi, i_byte};
        off      = r_pos - POS_W'(POS_PAYLOAD);
        off_ext  = OFF_W'(off);
        too_long = (17'(len_rx) > 17'(i_cfg.max_len)) || (17'(len_rx) > 17'(MAX_PAYLOAD));
        want     = (r_pos == POS_W'(POS_SYNC_A)) ? i_cfg.hdr_a :
                   (r_pos == POS_W'(POS_SYNC_B)) ? i_cfg.hdr_b : i_cfg.hdr_c;

        n_pos    = r_pos + POS_W'(1);
        n_crc    = r_crc;
        n_len    = r_len;
        n_tgt    = r_tgt;
        n_len_hi = r_len_hi;
        n_crc_hi = r_crc_hi;
        hunt     = 1'b0;

        res.byte_value    = i_byte;
        res.field_kind    = KIND_DROP;
        res.payload_index = '0;
        res.frame_end     = 1'b0;
        res.verdict       = VERD_NONE;

        priority if (r_pos < POS_W'(POS_SOURCE)) begin
            if (i_byte == want) begin
                res.field_kind = KIND_HEADER;
                n_crc          = crc_next;
            end else if (r_pos == POS_W'(POS_SYNC_A)) begin
                hunt = 1'b1;
            end else begin
                res.field_kind = KIND_HEADER;
                res.frame_end  = 1'b1;
                res.verdict    = VERD_BAD_HDR;
                hunt           = 1'b1;
            end
        end else if (r_pos < POS_W'(POS_PAYLOAD)) begin
            n_crc = crc_next;
            priority if (r_pos == POS_W'(POS_SOURCE)) begin
                res.field_kind = KIND_SOURCE;
            end else if (r_pos == POS_W'(POS_TARGET)) begin
                res.field_kind = KIND_TARGET;
                n_tgt          = i_byte;
            end else if (r_pos == POS_W'(POS_TYPE)) begin
                res.field_kind = KIND_TYPE;
            end else if (r_pos == POS_W'(POS_LEN_HI)) begin
                res.field_kind = KIND_LENGTH;
                n_len_hi       = i_byte;
            end else begin
                res.field_kind = KIND_LENGTH;
                if (too_long) begin
                    res.frame_end = 1'b1;
                    res.verdict   = VERD_TOO_LONG;
                    hunt          = 1'b1;
                end else begin
                    n_len = len_rx[LEN_W-1:0];
                end
            end
        end else if (off < POS_W'(r_len)) begin
            res.field_kind    = KIND_PAYLOAD;
            res.payload_index = off_ext[PIDX_W-1:0];
            n_crc             = crc_next;
        end else if (off == POS_W'(r_len)) begin
            res.field_kind = KIND_CRC;
            n_crc_hi       = i_byte;
        end else begin
            res.field_kind = KIND_CRC;
            res.frame_end  = 1'b1;
            if (crc_rx != r_crc) begin
                res.verdict = VERD_CRC_ERR;
            end else if (r_tgt != i_cfg.own_addr) begin
                res.verdict = VERD_FOREIGN;
            end else begin
                res.verdict = VERD_GOOD;
            end
            hunt = 1'b1;
        end

        if (hunt) begin
            n_pos    = '0;
            n_crc    = CRC_INIT;
            n_len    = '0;
            n_tgt    = '0;
            n_len_hi = '0;
            n_crc_hi = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= CRC_INIT;
            r_len    <= '0;
            r_tgt    <= '0;
            r_len_hi <= '0;
            r_crc_hi <= '0;
        end else if (i_step) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_len    <= n_len;
            r_tgt    <= n_tgt;
            r_len_hi <= n_len_hi;
            r_crc_hi <= n_crc_hi;
        end
    end

    assign o_res = res;

endmodule

`default_nettype wire

// ----- sv/serial_frame_receiver_crc16.sv -----
`default_nettype none

// Byte-stream frame receiver: every received byte comes back as one status item tagged with
// its field kind and payload offset; the byte that closes a frame attempt raises tlast and
// carries a verdict (good, CRC error, foreign target, bad header, too long). One byte is
// taken per clock cycle unless the result side stalls; each byte passes through the input
// register and then the result register, and the CRC-16 update of the byte and the frame
// state step both happen as it moves from one to the other. Result stalls stop the input
// only when both registers are full. Write configuration only while no byte is in flight.

module serial_frame_receiver_crc16
    import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] rx_byte

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [TDATA_W-1:0]        m_axis_tdata,   // [7:0] byte_value, [17:8] payload_index
    output logic                      m_axis_tlast,   // frame_end
    output logic [TUSER_W-1:0]        m_axis_tuser    // [2:0] field_kind, [5:3] verdict
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           res;
    logic              adv;
    logic              step;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv;
    assign step          = r_in_valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_a    <= '0;
            r_cfg.hdr_b    <= '0;
            r_cfg.hdr_c    <= '0;
            r_cfg.own_addr <= '0;
            r_cfg.max_len  <= CFG_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_HDR_A:   r_cfg.hdr_a    <= i_cfg_wdata[BYTE_W-1:0];
                CFG_HDR_B:   r_cfg.hdr_b    <= i_cfg_wdata[BYTE_W-1:0];
                CFG_HDR_C:   r_cfg.hdr_c    <= i_cfg_wdata[BYTE_W-1:0];
                CFG_OWN:     r_cfg.own_addr <= i_cfg_wdata[BYTE_W-1:0];
                CFG_MAX_LEN: r_cfg.max_len  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    sfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(TDATA_W - PIDX_W - BYTE_W)'(0), r_out.payload_index,
                            r_out.byte_value};
    assign m_axis_tlast  = r_out.frame_end;
    assign m_axis_tuser  = {r_out.verdict, r_out.field_kind};

endmodule

`default_nettype wire

// ----- sv/sfr_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module sfr_checker
    import sfr_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [TDATA_W-1:0]   m_axis_tdata,
    input wire logic                 m_axis_tlast,
    input wire logic [TUSER_W-1:0]   m_axis_tuser
);

    logic [KIND_W-1:0] kind;
    logic [VERD_W-1:0] verd;
    logic [PIDX_W-1:0] pidx;

    assign kind = m_axis_tuser[KIND_W-1:0];
    assign verd = m_axis_tuser[TUSER_W-1:KIND_W];
    assign pidx = m_axis_tdata[PIDX_W+BYTE_W-1:BYTE_W];

    `SFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    `SFR_ASSERT_IMPLIES(a_end_has_verdict, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast,
        verd != VERD_NONE)

    `SFR_ASSERT_IMPLIES(a_verdict_only_at_end, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tlast, verd == VERD_NONE)

    `SFR_ASSERT_IMPLIES(a_index_only_payload, i_clk, i_rst_n,
        m_axis_tvalid && (kind != KIND_PAYLOAD), pidx == '0)

endmodule

bind serial_frame_receiver_crc16 sfr_checker u_sfr_checker (.*);

`default_nettype wire

// ----- test/testbench.sv -----
module testbench;
    import sfr_pkg::*;

    localparam int PAYLOAD_CAP = 1024;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 130;
    localparam int NUM_PHASES  = 8;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr    = '0;
    logic [CFG_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tlast;
    logic [TUSER_W-1:0]   m_axis_tuser;

    serial_frame_receiver_crc16 #(
        .MAX_PAYLOAD(PAYLOAD_CAP)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    idle_mode_e idle_mode = IDLE_NONE;

    t_cfg        rx_cfg = '{hdr_a: 8'h00, hdr_b: 8'h00, hdr_c: 8'h00, own_addr: 8'h00,
                            max_len: 11'd1024};
    logic [10:0] rx_pos   = '0;
    logic [15:0] crc_acc  = CRC_INIT;
    logic [10:0] pay_len  = '0;
    logic [7:0]  tgt_seen = '0;
    logic [7:0]  len_hi   = '0;
    logic [7:0]  crc_hi   = '0;

    logic [BYTE_W-1:0] rx_bytes_pending[$];
    t_result           status_due[$];
    t_result           status_want;
    int                mismatches   = 0;
    int                items_queued = 0;
    int                quiet_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ data[i];
            r  = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic int payload_limit();
        return (rx_cfg.max_len > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(rx_cfg.max_len);
    endfunction

    function automatic void restart_hunt();
        rx_pos   = '0;
        crc_acc  = CRC_INIT;
        pay_len  = '0;
        tgt_seen = '0;
        len_hi   = '0;
        crc_hi   = '0;
    endfunction

    function automatic t_result predict_status(input logic [7:0] b);
        t_result     r;
        logic [7:0]  want;
        logic [15:0] len;
        int          pos;
        int          off;
        r            = '0;
        r.byte_value = b;
        pos          = int'(rx_pos);
        if (pos < POS_SOURCE) begin
            want = (pos == POS_SYNC_A) ? rx_cfg.hdr_a :
                   (pos == POS_SYNC_B) ? rx_cfg.hdr_b : rx_cfg.hdr_c;
            if (b == want) begin
                r.field_kind = KIND_HEADER;
                crc_acc      = crc16_step(crc_acc, b);
                rx_pos       = rx_pos + 1'b1;
            end else if (pos == POS_SYNC_A) begin
                restart_hunt();
            end else begin
                r.field_kind = KIND_HEADER;
                r.frame_end  = 1'b1;
                r.verdict    = VERD_BAD_HDR;
                restart_hunt();
            end
        end else if (pos < POS_PAYLOAD) begin
            crc_acc = crc16_step(crc_acc, b);
            rx_pos  = rx_pos + 1'b1;
            case (pos)
                POS_SOURCE: r.field_kind = KIND_SOURCE;
                POS_TARGET: begin
                    r.field_kind = KIND_TARGET;
                    tgt_seen     = b;
                end
                POS_TYPE: r.field_kind = KIND_TYPE;
                POS_LEN_HI: begin
                    r.field_kind = KIND_LENGTH;
                    len_hi       = b;
                end
                default: begin
                    r.field_kind = KIND_LENGTH;
                    len          = {len_hi, b};
                    if (len > payload_limit()) begin
                        r.frame_end = 1'b1;
                        r.verdict   = VERD_TOO_LONG;
                        restart_hunt();
                    end else begin
                        pay_len = len[10:0];
                    end
                end
            endcase
        end else begin
            off = pos - POS_PAYLOAD;
            if (off < pay_len) begin
                r.field_kind    = KIND_PAYLOAD;
                r.payload_index = off[PIDX_W-1:0];
                crc_acc         = crc16_step(crc_acc, b);
                rx_pos          = rx_pos + 1'b1;
            end else if (off == pay_len) begin
                r.field_kind = KIND_CRC;
                crc_hi       = b;
                rx_pos       = rx_pos + 1'b1;
            end else begin
                r.field_kind = KIND_CRC;
                r.frame_end  = 1'b1;
                if ({crc_hi, b} != crc_acc) begin
                    r.verdict = VERD_CRC_ERR;
                end else if (tgt_seen != rx_cfg.own_addr) begin
                    r.verdict = VERD_FOREIGN;
                end else begin
                    r.verdict = VERD_GOOD;
                end
                restart_hunt();
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_HDR_A:   rx_cfg.hdr_a    = value[7:0];
            CFG_HDR_B:   rx_cfg.hdr_b    = value[7:0];
            CFG_HDR_C:   rx_cfg.hdr_c    = value[7:0];
            CFG_OWN:     rx_cfg.own_addr = value[7:0];
            CFG_MAX_LEN: rx_cfg.max_len  = value;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (rx_bytes_pending.size() != 0 || s_axis_tvalid || status_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Stop after the length field when the length is over the limit.
    task automatic queue_frame(input logic [7:0] src, input logic [7:0] tgt,
                               input logic [7:0] ftype, input logic [15:0] len,
                               input logic [15:0] crc_flip);
        logic [7:0]  head[8];
        logic [7:0]  pb;
        logic [15:0] acc;
        head = '{rx_cfg.hdr_a, rx_cfg.hdr_b, rx_cfg.hdr_c, src, tgt, ftype,
                 len[15:8], len[7:0]};
        acc  = CRC_INIT;
        foreach (head[i]) begin
            rx_bytes_pending.push_back(head[i]);
            acc = crc16_step(acc, head[i]);
        end
        items_queued += 8;
        if (len <= payload_limit()) begin
            for (int i = 0; i < len; i++) begin
                pb = 8'($urandom);
                rx_bytes_pending.push_back(pb);
                acc = crc16_step(acc, pb);
            end
            acc = acc ^ crc_flip;
            rx_bytes_pending.push_back(acc[15:8]);
            rx_bytes_pending.push_back(acc[7:0]);
            items_queued += int'(len) + 2;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                status_due.push_back(predict_status(s_axis_tdata));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (rx_bytes_pending.size() != 0 &&
                    !((idle_mode == IDLE_SEND && $urandom_range(99) < 81) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(99) < 7))) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= rx_bytes_pending.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (status_due.size() == 0) begin
                    $display("%0t: item with nothing pending: expected none, actual tdata %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    status_want = status_due.pop_front();
                    check_field("byte_value", status_want.byte_value, m_axis_tdata[7:0]);
                    check_field("payload_index", status_want.payload_index,
                                m_axis_tdata[17:8]);
                    check_field("frame_end", status_want.frame_end, m_axis_tlast);
                    check_field("field_kind", status_want.field_kind, m_axis_tuser[2:0]);
                    check_field("verdict", status_want.verdict, m_axis_tuser[5:3]);
                end
            end
            m_axis_tready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 81) ||
                               (idle_mode == IDLE_BOTH && $urandom_range(99) < 7));
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (rx_bytes_pending.size() == 0 && !s_axis_tvalid && status_due.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          target;
        int          roll;
        int          lim;
        logic [15:0] len;
        logic [15:0] flip;
        logic [7:0]  tgt;
        logic [7:0]  w;
        logic [10:0] max_len;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: all sync bytes and own address zero, limit 1024.
        rx_bytes_pending.push_back(8'hFF);
        rx_bytes_pending.push_back(8'h00);
        rx_bytes_pending.push_back(8'hFF);
        rx_bytes_pending.push_back(8'h00);
        rx_bytes_pending.push_back(8'h00);
        rx_bytes_pending.push_back(8'hFF);
        items_queued += 6;
        queue_frame(8'hFF, 8'h00, 8'h80, 16'd1, 16'h0000);
        queue_frame(8'h00, 8'h00, 8'h7F, 16'h0401, 16'h0000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                0: max_len = 11'd1024;
                1: max_len = 11'd2047;
                2: max_len = 11'd0;
                3: max_len = 11'($urandom_range(40, 1));
                default: begin
                    case ($urandom_range(2))
                        0: max_len = 11'($urandom_range(40, 0));
                        1: max_len = 11'd1024;
                        default: max_len = 11'($urandom_range(2047, 1025));
                    endcase
                end
            endcase
            if (p == 1) begin
                write_reg(CFG_HDR_A, 11'h0FF);
                write_reg(CFG_HDR_B, 11'h0FF);
                write_reg(CFG_HDR_C, 11'h0FF);
                write_reg(CFG_OWN, 11'h0FF);
            end else if (p == 2) begin
                write_reg(CFG_HDR_A, 11'h000);
                write_reg(CFG_HDR_B, 11'h000);
                write_reg(CFG_HDR_C, 11'h000);
                write_reg(CFG_OWN, 11'h000);
            end else begin
                write_reg(CFG_HDR_A, 11'($urandom_range(255)));
                write_reg(CFG_HDR_B, 11'($urandom_range(255)));
                write_reg(CFG_HDR_C, 11'($urandom_range(255)));
                write_reg(CFG_OWN, 11'($urandom_range(255)));
            end
            write_reg(CFG_MAX_LEN, max_len);
            idle_mode = idle_mode_e'(p % 4);
            lim       = payload_limit();

            if (p == 1) begin
                queue_frame(8'($urandom), rx_cfg.own_addr, 8'($urandom), 16'd1025, 16'h0000);
            end

            target = items_queued + PHASE_ITEMS;
            while (items_queued < target) begin
                roll = $urandom_range(99);
                if (roll < 66) begin
                    len = 16'($urandom_range((lim < 24) ? lim : 24, 0));
                    if ($urandom_range(19) == 0 && lim <= 64) begin
                        len = 16'(lim);
                    end
                    tgt  = ($urandom_range(3) != 0) ? rx_cfg.own_addr : 8'($urandom);
                    flip = ($urandom_range(99) < 15) ? 16'($urandom_range(16'hFFFF, 1)) : 16'h0;
                    queue_frame(8'($urandom), tgt, 8'($urandom), len, flip);
                end else if (roll < 78) begin
                    len = $urandom_range(1) ? 16'(lim + 1) : 16'($urandom_range(16'hFFFF, lim + 1));
                    queue_frame(8'($urandom), 8'($urandom), 8'($urandom), len, 16'h0000);
                end else if (roll < 90) begin
                    rx_bytes_pending.push_back(rx_cfg.hdr_a);
                    w = 8'($urandom);
                    if ($urandom_range(1)) begin
                        while (w == rx_cfg.hdr_b) w = 8'($urandom);
                        rx_bytes_pending.push_back(w);
                        items_queued += 2;
                    end else begin
                        while (w == rx_cfg.hdr_c) w = 8'($urandom);
                        rx_bytes_pending.push_back(rx_cfg.hdr_b);
                        rx_bytes_pending.push_back(w);
                        items_queued += 3;
                    end
                end else begin
                    repeat ($urandom_range(3, 1)) begin
                        w = 8'($urandom);
                        while (w == rx_cfg.hdr_a) w = 8'($urandom);
                        rx_bytes_pending.push_back(w);
                        items_queued += 1;
                    end
                end
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
